@@ design/symmetric_2x2_eigen_solver_defines.svh @@
// Assertion macros shared by the eigen solver RTL
`ifndef SYMMETRIC_2X2_EIGEN_SOLVER_DEFINES_SVH
`define SYMMETRIC_2X2_EIGEN_SOLVER_DEFINES_SVH

// condition must hold at every edge outside reset
`define S2ES_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define S2ES_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/s2es_pkg.sv @@
// Shared widths and constants for the 2x2 eigen solver
`timescale 1ns / 1ps
`default_nettype none
package s2es_pkg;
    localparam int VEC_FRAC_BITS = 30;
    localparam int IN_W = 31;
    localparam int XY_W = 32;
    localparam int TR_W = 32;
    localparam int LAM_W = 34;
    localparam int VEC_W = 32;
    localparam int MAG_W = 33;
    localparam int SQ_IN_W = 68;
    localparam int ROOT_W = 34;
    localparam int SB_W = 140;
    localparam int NUM_W = MAG_W + VEC_FRAC_BITS + 1;
    localparam int QUO_W = VEC_FRAC_BITS + 1;
    localparam int NORM_STEPS = 6;
    localparam int NORM_MAX = MAG_W - 1;
endpackage
`default_nettype wire

@@ design/symmetric_2x2_eigen_solver.sv @@
// Top level: streaming eigen decomposition of a symmetric 2x2 tensor
// Usage:
//   Input channel tensor_valid/tensor_stall carries one request with a, b, d
//   (tensor_xx, tensor_xy, tensor_yy). Output channel eigen_valid/eigen_stall
//   carries both eigenvalues, the unit major vector, the minor vector and the
//   degenerate flag. A request is taken when valid is high and stall is low.
//   Throughput: one request per cycle, sustained while eigen_stall does not
//   hold a valid result. Pipeline: two 35-stage square-root pipelines (one
//   root bit per stage, the last stage rounding) and a 31-stage divider
//   (one quotient bit per stage), with their setup stages.
//   When eigen_stall holds a valid result, the whole pipeline freezes and
//   tensor_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits; the block takes requests right after reset.
//   Zero vector case (b = 0 and l1 = a): major vector (1,0), degenerate = 1.
`timescale 1ns / 1ps
`default_nettype none
`include "symmetric_2x2_eigen_solver_defines.svh"
module symmetric_2x2_eigen_solver import s2es_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    tensor_valid,
    output logic                    tensor_stall,
    input  logic [IN_W-1:0]         tensor_xx,
    input  logic signed [XY_W-1:0]  tensor_xy,
    input  logic [IN_W-1:0]         tensor_yy,
    output logic                    eigen_valid,
    input  logic                    eigen_stall,
    output logic signed [LAM_W-1:0] lambda_major,
    output logic signed [LAM_W-1:0] lambda_minor,
    output logic signed [VEC_W-1:0] major_vec_x,
    output logic signed [VEC_W-1:0] major_vec_y,
    output logic signed [VEC_W-1:0] minor_vec_x,
    output logic signed [VEC_W-1:0] minor_vec_y,
    output logic                    degenerate
);
    localparam int DIV_W = NUM_W + 1;

    typedef struct packed {
        logic [TR_W-1:0] tr;
        logic [IN_W-1:0] a;
        logic            bneg;
        logic [XY_W-1:0] babs;
    } sb1_t;

    typedef struct packed {
        logic [LAM_W-1:0] l1;
        logic [LAM_W-1:0] l2;
        logic [MAG_W-1:0] xs;
        logic [MAG_W-1:0] ys;
        logic             bneg;
        logic             yneg;
        logic             degen;
    } sb2_t;

    logic en;

    // front end
    logic              v0_reg, v1_reg, v2_reg, v3_reg;
    logic [IN_W-1:0]   a0_reg, d0_reg;
    logic [XY_W-1:0]   b0_reg;
    logic [IN_W-1:0]   dabs1_reg;
    sb1_t              s1_reg, s2_reg;
    logic [2*IN_W-1:0] dsq2_reg;
    logic [2*XY_W-1:0] bsq2_reg;
    logic [SQ_IN_W-1:0] sq1_in_reg;
    sb1_t              s3_reg;

    // first root
    logic              r1_vld;
    logic [ROOT_W-1:0] delta;
    logic [SB_W-1:0]   r1_sb;
    sb1_t              r1_s;

    // eigenvalues
    logic              v4_reg, v5_reg;
    logic [LAM_W-1:0]  l1_4_reg, l2_4_reg;
    logic [LAM_W:0]    y4_reg;
    logic              bneg4_reg;
    logic [XY_W-1:0]   babs4_reg;
    logic [LAM_W:0]    sum4, l2_wide, y_wide, yabs5;
    sb2_t              s5_reg, s5_next;

    // normalization
    logic [NORM_STEPS-1:0] nv_reg, nv_next;
    sb2_t              ns_reg [NORM_STEPS];
    sb2_t              ns_next [NORM_STEPS];

    // squares and second root
    logic              v6_reg, v7_reg;
    logic [2*MAG_W-1:0] xsq6_reg, ysq6_reg;
    sb2_t              s6_reg, s7_reg;
    logic [SQ_IN_W-1:0] sq2_in_reg;
    logic              r2_vld;
    logic [ROOT_W-1:0] len;
    logic [SB_W-1:0]   r2_sb;
    sb2_t              r2_s;

    // division
    logic              v8_reg;
    logic [NUM_W-1:0]  numx8_reg, numy8_reg;
    logic [ROOT_W-1:0] len8_reg;
    sb2_t              s8_reg;
    logic [QUO_W-1:0]  dv_reg, dv_next;
    logic [NUM_W-1:0]  rx_reg [QUO_W];
    logic [NUM_W-1:0]  rx_next [QUO_W];
    logic [NUM_W-1:0]  ry_reg [QUO_W];
    logic [NUM_W-1:0]  ry_next [QUO_W];
    logic [QUO_W-1:0]  qx_reg [QUO_W];
    logic [QUO_W-1:0]  qx_next [QUO_W];
    logic [QUO_W-1:0]  qy_reg [QUO_W];
    logic [QUO_W-1:0]  qy_next [QUO_W];
    logic [ROOT_W-1:0] dl_reg [QUO_W];
    logic [ROOT_W-1:0] dl_next [QUO_W];
    sb2_t              ds_reg [QUO_W];
    sb2_t              ds_next [QUO_W];

    // output register
    logic              out_vld_reg;
    logic [LAM_W-1:0]  lmaj_reg, lmin_reg;
    logic [VEC_W-1:0]  mx_reg, my_reg, nx_reg, ny_reg;
    logic              degen_reg;
    logic [VEC_W-1:0]  mx_next, my_next;
    sb2_t              dlast;

    assign en = !(out_vld_reg && eigen_stall);
    assign tensor_stall = !en;

    // ---------------- front end ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            nv_reg <= '0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            dv_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= tensor_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= r1_vld;
            v5_reg <= v4_reg;
            nv_reg <= nv_next;
            v6_reg <= nv_reg[NORM_STEPS-1];
            v7_reg <= v6_reg;
            v8_reg <= r2_vld;
            dv_reg <= dv_next;
            out_vld_reg <= dv_reg[QUO_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg <= tensor_xx;
            d0_reg <= tensor_yy;
            b0_reg <= tensor_xy;

            s1_reg.tr <= TR_W'(a0_reg) + TR_W'(d0_reg);
            s1_reg.a <= a0_reg;
            s1_reg.bneg <= b0_reg[XY_W-1];
            s1_reg.babs <= b0_reg[XY_W-1] ? (~b0_reg + 1'b1) : b0_reg;
            dabs1_reg <= (a0_reg >= d0_reg) ? (a0_reg - d0_reg) : (d0_reg - a0_reg);

            dsq2_reg <= dabs1_reg * dabs1_reg;
            bsq2_reg <= s1_reg.babs * s1_reg.babs;
            s2_reg <= s1_reg;

            // (a-d)^2 + (2b)^2
            sq1_in_reg <= SQ_IN_W'(dsq2_reg) + (SQ_IN_W'(bsq2_reg) << 2);
            s3_reg <= s2_reg;
        end
    end

    s2es_sqrt u_sqrt_delta (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_val    (sq1_in_reg),
        .in_sb     (SB_W'(s3_reg)),
        .out_valid (r1_vld),
        .out_root  (delta),
        .out_sb    (r1_sb)
    );

    assign r1_s = sb1_t'(r1_sb[$bits(sb1_t)-1:0]);

    // ---------------- eigenvalues ----------------
    always_comb
    begin
        sum4 = (LAM_W+1)'(r1_s.tr) + (LAM_W+1)'(delta) + (LAM_W+1)'(1);
        l2_wide = (LAM_W+1)'(r1_s.tr) - (LAM_W+1)'(sum4[LAM_W:1]);
        y_wide = (LAM_W+1)'(sum4[LAM_W:1]) - (LAM_W+1)'(r1_s.a);

        yabs5 = y4_reg[LAM_W] ? (~y4_reg + 1'b1) : y4_reg;
        s5_next.l1 = l1_4_reg;
        s5_next.l2 = l2_4_reg;
        s5_next.xs = MAG_W'(babs4_reg);
        s5_next.ys = yabs5[MAG_W-1:0];
        s5_next.bneg = bneg4_reg;
        s5_next.yneg = y4_reg[LAM_W];
        s5_next.degen = (babs4_reg == '0) && (yabs5 == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l1_4_reg <= sum4[LAM_W:1];
            l2_4_reg <= l2_wide[LAM_W-1:0];
            y4_reg <= y_wide;
            bneg4_reg <= r1_s.bneg;
            babs4_reg <= r1_s.babs;
            s5_reg <= s5_next;
        end
    end

    // ---------------- normalization: shifts 32,16,8,4,2,1 ----------------
    always_comb
    begin
        sb2_t nin;
        int   s;
        for (int i = 0; i < NORM_STEPS; i++)
        begin
            s = NORM_MAX >> i;
            if (i == 0)
            begin
                nin = s5_reg;
                nv_next[i] = v5_reg;
            end
            else
            begin
                nin = ns_reg[i-1];
                nv_next[i] = nv_reg[i-1];
            end
            ns_next[i] = nin;
            if (((nin.xs | nin.ys) >> (MAG_W - s)) == '0)
            begin
                ns_next[i].xs = nin.xs << s;
                ns_next[i].ys = nin.ys << s;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NORM_STEPS; i++)
                ns_reg[i] <= ns_next[i];

            xsq6_reg <= ns_reg[NORM_STEPS-1].xs * ns_reg[NORM_STEPS-1].xs;
            ysq6_reg <= ns_reg[NORM_STEPS-1].ys * ns_reg[NORM_STEPS-1].ys;
            s6_reg <= ns_reg[NORM_STEPS-1];

            sq2_in_reg <= SQ_IN_W'(xsq6_reg) + SQ_IN_W'(ysq6_reg);
            s7_reg <= s6_reg;
        end
    end

    s2es_sqrt u_sqrt_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v7_reg),
        .in_val    (sq2_in_reg),
        .in_sb     (SB_W'(s7_reg)),
        .out_valid (r2_vld),
        .out_root  (len),
        .out_sb    (r2_sb)
    );

    assign r2_s = sb2_t'(r2_sb[$bits(sb2_t)-1:0]);

    // ---------------- division, one quotient bit per stage ----------------
    always_comb
    begin
        logic [NUM_W-1:0]  xin, yin;
        logic [QUO_W-1:0]  qxin, qyin;
        logic [ROOT_W-1:0] lin;
        logic [DIV_W-1:0]  trial;
        int                k;
        for (int i = 0; i < QUO_W; i++)
        begin
            k = VEC_FRAC_BITS - i;
            if (i == 0)
            begin
                xin = numx8_reg;
                yin = numy8_reg;
                qxin = '0;
                qyin = '0;
                lin = len8_reg;
                ds_next[i] = s8_reg;
                dv_next[i] = v8_reg;
            end
            else
            begin
                xin = rx_reg[i-1];
                yin = ry_reg[i-1];
                qxin = qx_reg[i-1];
                qyin = qy_reg[i-1];
                lin = dl_reg[i-1];
                ds_next[i] = ds_reg[i-1];
                dv_next[i] = dv_reg[i-1];
            end
            dl_next[i] = lin;
            trial = DIV_W'(lin) << k;
            if (DIV_W'(xin) >= trial)
            begin
                rx_next[i] = xin - trial[NUM_W-1:0];
                qx_next[i] = qxin | ({{(QUO_W-1){1'b0}}, 1'b1} << k);
            end
            else
            begin
                rx_next[i] = xin;
                qx_next[i] = qxin;
            end
            if (DIV_W'(yin) >= trial)
            begin
                ry_next[i] = yin - trial[NUM_W-1:0];
                qy_next[i] = qyin | ({{(QUO_W-1){1'b0}}, 1'b1} << k);
            end
            else
            begin
                ry_next[i] = yin;
                qy_next[i] = qyin;
            end
        end
    end

    assign dlast = ds_reg[QUO_W-1];

    always_comb
    begin
        if (dlast.degen)
        begin
            mx_next = VEC_W'(1) << VEC_FRAC_BITS;
            my_next = '0;
        end
        else
        begin
            mx_next = dlast.bneg ? -VEC_W'(qx_reg[QUO_W-1]) : VEC_W'(qx_reg[QUO_W-1]);
            my_next = dlast.yneg ? -VEC_W'(qy_reg[QUO_W-1]) : VEC_W'(qy_reg[QUO_W-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // (|c| << frac) + len/2, rounds the quotient half up
            numx8_reg <= (NUM_W'(r2_s.xs) << VEC_FRAC_BITS) + NUM_W'(len >> 1);
            numy8_reg <= (NUM_W'(r2_s.ys) << VEC_FRAC_BITS) + NUM_W'(len >> 1);
            len8_reg <= len;
            s8_reg <= r2_s;

            for (int i = 0; i < QUO_W; i++)
            begin
                rx_reg[i] <= rx_next[i];
                ry_reg[i] <= ry_next[i];
                qx_reg[i] <= qx_next[i];
                qy_reg[i] <= qy_next[i];
                dl_reg[i] <= dl_next[i];
                ds_reg[i] <= ds_next[i];
            end

            lmaj_reg <= dlast.l1;
            lmin_reg <= dlast.l2;
            mx_reg <= mx_next;
            my_reg <= my_next;
            nx_reg <= -my_next;
            ny_reg <= mx_next;
            degen_reg <= dlast.degen;
        end
    end

    assign eigen_valid = out_vld_reg;
    assign lambda_major = lmaj_reg;
    assign lambda_minor = lmin_reg;
    assign major_vec_x = mx_reg;
    assign major_vec_y = my_reg;
    assign minor_vec_x = nx_reg;
    assign minor_vec_y = ny_reg;
    assign degenerate = degen_reg;

    `S2ES_ASSERT_HOLDS(a_stall_src, tensor_stall == (eigen_valid && eigen_stall), "stall path")
    `S2ES_ASSERT_IMPLIES(a_degen_vec, eigen_valid && degenerate, major_vec_x == (VEC_W'(1) << VEC_FRAC_BITS) && major_vec_y == '0, "degenerate vector")
    `S2ES_ASSERT_IMPLIES(a_lambda_order, eigen_valid, lambda_major >= lambda_minor, "eigenvalue order")
    `S2ES_ASSERT_IMPLIES(a_major_y_sign, eigen_valid, !major_vec_y[VEC_W-1], "major y negative")
endmodule
`default_nettype wire

@@ design/s2es_sqrt.sv @@
// Pipelined rounded integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module s2es_sqrt import s2es_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [SQ_IN_W-1:0]  in_val,
    input  logic [SB_W-1:0]     in_sb,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   out_root,
    output logic [SB_W-1:0]     out_sb
);
    localparam int T_W = SQ_IN_W + 2;

    logic [SQ_IN_W-1:0] rem_reg [ROOT_W];
    logic [SQ_IN_W-1:0] rem_next [ROOT_W];
    logic [ROOT_W-1:0]  root_reg [ROOT_W];
    logic [ROOT_W-1:0]  root_next [ROOT_W];
    logic [SB_W-1:0]    sb_reg [ROOT_W];
    logic [SB_W-1:0]    sb_next [ROOT_W];
    logic [ROOT_W-1:0]  vld_reg;
    logic [ROOT_W-1:0]  vld_next;
    logic [ROOT_W-1:0]  res_reg;
    logic [ROOT_W-1:0]  res_next;
    logic [SB_W-1:0]    res_sb_reg;
    logic               res_vld_reg;

    always_comb
    begin
        logic [SQ_IN_W-1:0] rin;
        logic [ROOT_W-1:0]  qin;
        logic [T_W-1:0]     trial;
        int                 k;
        for (int i = 0; i < ROOT_W; i++)
        begin
            k = ROOT_W - 1 - i;
            if (i == 0)
            begin
                rin = in_val;
                qin = '0;
                sb_next[i] = in_sb;
                vld_next[i] = in_valid;
            end
            else
            begin
                rin = rem_reg[i-1];
                qin = root_reg[i-1];
                sb_next[i] = sb_reg[i-1];
                vld_next[i] = vld_reg[i-1];
            end
            // (2r + 2^k) * 2^k against the remainder v - r^2
            trial = ({{(T_W-ROOT_W){1'b0}}, qin} << (k + 1))
                  | ({{(T_W-1){1'b0}}, 1'b1} << (2 * k));
            if ({{(T_W-SQ_IN_W){1'b0}}, rin} >= trial)
            begin
                rem_next[i] = rin - trial[SQ_IN_W-1:0];
                root_next[i] = qin | ({{(ROOT_W-1){1'b0}}, 1'b1} << k);
            end
            else
            begin
                rem_next[i] = rin;
                root_next[i] = qin;
            end
        end
        // round up when v > r^2 + r
        if (rem_reg[ROOT_W-1] > {{(SQ_IN_W-ROOT_W){1'b0}}, root_reg[ROOT_W-1]})
            res_next = root_reg[ROOT_W-1] + {{(ROOT_W-1){1'b0}}, 1'b1};
        else
            res_next = root_reg[ROOT_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            res_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
            res_vld_reg <= vld_reg[ROOT_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < ROOT_W; i++)
            begin
                rem_reg[i] <= rem_next[i];
                root_reg[i] <= root_next[i];
                sb_reg[i] <= sb_next[i];
            end
            res_reg <= res_next;
            res_sb_reg <= sb_reg[ROOT_W-1];
        end
    end

    assign out_valid = res_vld_reg;
    assign out_root = res_reg;
    assign out_sb = res_sb_reg;
endmodule
`default_nettype wire
